// ===== rtl/icmp_hfe_pkg.sv =====
// Package for the ICMP header field extractor.
// Holds the result item type, ICMP type and code constants, status codes and sizes.
// No dependencies; every other file in rtl imports it.
`timescale 1ns / 1ps

package icmp_hfe_pkg;

    // Byte count at which parsing stops; bytes at this position and later are ignored.
    localparam logic [15:0] MAX_MESSAGE_BYTES = 16'hFFFF;

    // Reset value of the router entry cap register.
    localparam logic [7:0] MAX_ROUTER_ENTRIES_RST = 8'd50;

    // Depth of the result queue and its pointer and count widths.
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // ICMP type codes that carry decoded fields.
    localparam logic [7:0] ICMP_ECHO_RSP    = 8'd0;
    localparam logic [7:0] ICMP_UNREACH     = 8'd3;
    localparam logic [7:0] ICMP_REDIR_GW    = 8'd5;
    localparam logic [7:0] ICMP_ECHO_REQ    = 8'd8;
    localparam logic [7:0] ICMP_ROUTER_ADV  = 8'd9;
    localparam logic [7:0] ICMP_PARAM_PROB  = 8'd12;
    localparam logic [7:0] ICMP_TS_REQ      = 8'd13;
    localparam logic [7:0] ICMP_TS_REPLY    = 8'd14;
    localparam logic [7:0] ICMP_MASK_REQ    = 8'd17;
    localparam logic [7:0] ICMP_MASK_REPLY  = 8'd18;

    // Destination unreachable code that carries a next-hop MTU.
    localparam logic [7:0] CODE_FRAG_NEEDED = 8'd4;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;
    localparam logic [1:0] ST_CAPPED = 2'd3;

    // One result item.
    typedef struct packed {
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic        checksum_ok;
        logic [1:0]  status;
        logic [15:0] ident;
        logic [15:0] sequence_res;
        logic [15:0] aux_value;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic [31:0] word_three;
        logic [15:0] item_count;
        logic        last;
    } t_result;

    // Results produced by one accepted byte: an optional router entry,
    // then an optional message summary.
    typedef struct packed {
        logic    entry_vld;
        logic    sum_vld;
        t_result entry;
        t_result summary;
    } t_push;

endpackage

// ===== rtl/icmp_hfe_parser.sv =====
// Byte parser of the ICMP header field extractor: message state, checksum and field decode.
// Depends on icmp_hfe_pkg; feeds icmp_hfe_out_queue through a t_push struct.
`timescale 1ns / 1ps

module icmp_hfe_parser
    import icmp_hfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_write,
    input  logic [7:0]  i_cfg_data,
    output t_push       o_push
);

    // Message state registers.
    logic [15:0] r_pos;
    logic [15:0] r_acc;
    logic [7:0]  r_held;
    logic [7:0]  r_type;
    logic [7:0]  r_code;
    logic [7:0]  r_fc [16];
    logic [15:0] r_adv;
    logic [63:0] r_shift;
    logic [9:0]  r_prog;
    logic [7:0]  r_done;
    logic [7:0]  r_max;

    logic [15:0] n_pos;
    logic [15:0] n_acc;
    logic [7:0]  n_held;
    logic [7:0]  n_type;
    logic [7:0]  n_code;
    logic [7:0]  n_fc [16];
    logic [15:0] n_adv;
    logic [63:0] n_shift;
    logic [9:0]  n_prog;
    logic [7:0]  n_done;

    logic        active;
    logic        add_en;
    logic [15:0] add_word;
    logic [16:0] sum_raw;
    logic [15:0] sum_fold;
    logic [9:0]  period;
    logic [9:0]  prog_inc;
    logic        entry_hit;
    t_result     entry_res;
    t_result     sum_res;

    // Per-byte update of the message state and both result items.
    always_comb begin
        active   = (r_pos != MAX_MESSAGE_BYTES);
        n_pos    = active ? r_pos + 16'd1 : r_pos;
        n_held   = r_held;
        n_type   = r_type;
        n_code   = r_code;
        n_fc     = r_fc;
        n_adv    = r_adv;
        n_shift  = r_shift;
        n_prog   = r_prog;
        n_done   = r_done;
        entry_hit = 1'b0;

        if (active && !r_pos[0]) begin
            n_held = i_data_byte;
        end
        if (active && r_pos == 16'd0) begin
            n_type = i_data_byte;
        end
        if (active && r_pos == 16'd1) begin
            n_code = i_data_byte;
        end
        if (active && r_pos >= 16'd4 && r_pos < 16'd20) begin
            n_fc[4'(r_pos - 16'd4)] = i_data_byte;
        end
        if (active && r_pos == 16'd5) begin
            n_adv = {r_fc[0], i_data_byte};
        end

        // Router advertisement entries: eight address bytes, then padding words.
        period   = (r_adv[7:0] > 8'd2) ? 10'd8 + {(r_adv[7:0] - 8'd2), 2'b00} : 10'd8;
        prog_inc = r_prog + 10'd1;
        if (active && n_type == ICMP_ROUTER_ADV && r_pos >= 16'd8) begin
            if (r_prog < 10'd8) begin
                n_shift = {r_shift[55:0], i_data_byte};
            end
            if (r_prog == 10'd7 && r_done < r_adv[15:8] && r_done < r_max) begin
                entry_hit = 1'b1;
                n_done    = r_done + 8'd1;
            end
            n_prog = (prog_inc >= period) ? 10'd0 : prog_inc;
        end

        // Ones' complement checksum; an odd final byte is padded with zero.
        add_en   = 1'b0;
        add_word = 16'h0000;
        if (active && r_pos[0]) begin
            add_en   = 1'b1;
            add_word = {r_held, i_data_byte};
        end else if (i_last_byte && n_pos[0]) begin
            add_en   = 1'b1;
            add_word = {n_held, 8'h00};
        end
        sum_raw  = {1'b0, r_acc} + {1'b0, add_word};
        sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};
        n_acc    = add_en ? sum_fold : r_acc;

        // Router entry result item.
        entry_res              = '0;
        entry_res.msg_type     = n_type;
        entry_res.msg_code     = n_code;
        entry_res.aux_value    = {n_fc[2], n_fc[3]};
        entry_res.word_one     = n_shift[63:32];
        entry_res.word_two     = n_shift[31:0];
        entry_res.item_count   = {8'h00, n_done};
        entry_res.last         = 1'b0;

        // Message summary item.
        sum_res          = '0;
        sum_res.msg_type = n_type;
        sum_res.msg_code = n_code;
        sum_res.last     = 1'b1;
        if (n_pos < 16'd4) begin
            sum_res.status = ST_SHORT;
        end else begin
            sum_res.checksum_ok = (n_acc == 16'hFFFF);
            unique case (n_type) inside
                ICMP_ECHO_RSP, ICMP_ECHO_REQ: begin
                    if (n_pos >= 16'd8) begin
                        sum_res.ident        = {n_fc[0], n_fc[1]};
                        sum_res.sequence_res = {n_fc[2], n_fc[3]};
                        sum_res.item_count   = n_pos - 16'd8;
                    end
                end
                ICMP_UNREACH: begin
                    if (n_pos >= 16'd8 && n_code == CODE_FRAG_NEEDED) begin
                        sum_res.aux_value = {n_fc[2], n_fc[3]};
                    end
                end
                ICMP_REDIR_GW: begin
                    if (n_pos >= 16'd8) begin
                        sum_res.word_one = {n_fc[0], n_fc[1], n_fc[2], n_fc[3]};
                    end
                end
                ICMP_PARAM_PROB: begin
                    if (n_pos >= 16'd8) begin
                        sum_res.aux_value = {8'h00, n_fc[0]};
                    end
                end
                ICMP_TS_REQ, ICMP_TS_REPLY: begin
                    if (n_pos >= 16'd20) begin
                        sum_res.ident        = {n_fc[0], n_fc[1]};
                        sum_res.sequence_res = {n_fc[2], n_fc[3]};
                        sum_res.word_one     = {n_fc[4], n_fc[5], n_fc[6], n_fc[7]};
                        sum_res.word_two     = {n_fc[8], n_fc[9], n_fc[10], n_fc[11]};
                        sum_res.word_three   = {n_fc[12], n_fc[13], n_fc[14], n_fc[15]};
                    end else begin
                        sum_res.status = ST_TRUNC;
                    end
                end
                ICMP_MASK_REQ, ICMP_MASK_REPLY: begin
                    if (n_pos >= 16'd12) begin
                        sum_res.ident        = {n_fc[0], n_fc[1]};
                        sum_res.sequence_res = {n_fc[2], n_fc[3]};
                        sum_res.word_one     = {n_fc[4], n_fc[5], n_fc[6], n_fc[7]};
                    end else begin
                        sum_res.status = ST_TRUNC;
                    end
                end
                ICMP_ROUTER_ADV: begin
                    if (n_pos >= 16'd8) begin
                        sum_res.aux_value  = {n_fc[2], n_fc[3]};
                        sum_res.item_count = {8'h00, n_done};
                        if (n_adv[15:8] > r_max) begin
                            sum_res.status = ST_CAPPED;
                        end
                    end else begin
                        sum_res.status = ST_TRUNC;
                    end
                end
                default: begin
                end
            endcase
        end

        o_push.entry_vld = i_accept && entry_hit;
        o_push.sum_vld   = i_accept && i_last_byte;
        o_push.entry     = entry_res;
        o_push.summary   = sum_res;
    end

    // State update; the summary clears all message state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos   <= '0;
            r_acc   <= '0;
            r_held  <= '0;
            r_type  <= '0;
            r_code  <= '0;
            r_fc    <= '{default: '0};
            r_adv   <= '0;
            r_shift <= '0;
            r_prog  <= '0;
            r_done  <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_type  <= n_type;
            r_code  <= n_code;
            r_fc    <= n_fc;
            r_adv   <= n_adv;
            r_shift <= n_shift;
            r_prog  <= n_prog;
            r_done  <= n_done;
        end
    end

    // Router entry cap register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_ROUTER_ENTRIES_RST;
        end else if (i_cfg_write) begin
            r_max <= i_cfg_data;
        end
    end

    // A summary leaves the parser at the start of a new message.
    a_clear_after_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.sum_vld |=> (r_pos == 16'd0 && r_done == 8'd0 && r_acc == 16'd0))
        else $error("message state not cleared after summary");

    // Router entries only come from router advertisements.
    a_entry_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.entry_vld |-> (n_type == ICMP_ROUTER_ADV && r_pos >= 16'd8))
        else $error("router entry outside a router advertisement");

    // Each entry result advances the decoded entry count by one.
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.entry_vld && !o_push.sum_vld) |=> (r_done == $past(r_done) + 8'd1))
        else $error("entry count did not advance");

endmodule

// ===== rtl/icmp_hfe_out_queue.sv =====
// ICMP header field extractor result queue: up to two pushes, one unstalled pop a cycle.
// Depends on icmp_hfe_pkg for t_result, t_push and the queue sizes.
`timescale 1ns / 1ps

module icmp_hfe_out_queue
    import icmp_hfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result,
    output logic    o_full
);

    t_result             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_CNT_W-1:0]  r_count;

    logic [Q_PTR_W-1:0]  n_wr;
    logic [Q_PTR_W-1:0]  n_rd;
    logic [Q_CNT_W-1:0]  n_count;
    logic [1:0]          push_n;
    logic                pop;
    t_result             first_item;

    // Pointer and count arithmetic.
    always_comb begin
        push_n     = {1'b0, i_push.entry_vld} + {1'b0, i_push.sum_vld};
        pop        = o_out_valid && !i_out_stall;
        first_item = i_push.entry_vld ? i_push.entry : i_push.summary;
        n_wr       = r_wr + Q_PTR_W'(push_n);
        n_rd       = r_rd + Q_PTR_W'(pop);
        n_count    = r_count + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end

    assign o_out_valid = (r_count != '0);
    assign o_result    = r_mem[r_rd];
    assign o_full      = (r_count > Q_CNT_W'(Q_DEPTH - 2));

    // Storage; the summary follows the entry when both arrive together.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= first_item;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr + Q_PTR_W'(1)] <= i_push.summary;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // The count never passes the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // Nothing is pushed while fewer than two slots are free.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (push_n == 2'd0))
        else $error("push into full result queue");

endmodule

// ===== rtl/icmp_hfe_top.sv =====
// Top level of the ICMP header field extractor: ports, handshakes and wiring.
// Depends on icmp_hfe_pkg, icmp_hfe_parser and icmp_hfe_out_queue.
`timescale 1ns / 1ps

// The block takes one ICMP message byte per cycle while not stalled and decodes
// it combinationally from the parser's state registers into a four-item result queue.
// A byte yields no result, one result, or a router entry followed by the
// message summary. The input stalls only while fewer than two queue slots
// are free, so with a consumer that keeps up the block sustains one byte per
// clock, and each result is registered into the queue as its byte is accepted.
// The entry cap register can be written at any cycle; the ready signal is
// always high, and a write takes effect for the next accepted byte.
module icmp_header_field_extractor_top
    import icmp_hfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_msg_code,
    output logic        o_checksum_ok,
    output logic [1:0]  o_status,
    output logic [15:0] o_ident,
    output logic [15:0] o_sequence_res,
    output logic [15:0] o_aux_value,
    output logic [31:0] o_word_one,
    output logic [31:0] o_word_two,
    output logic [31:0] o_word_three,
    output logic [15:0] o_item_count,
    output logic        o_last
);

    logic    accept;
    logic    q_full;
    t_push   push;
    t_result res;

    // Input handshake.
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    icmp_hfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    icmp_hfe_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (res),
        .o_full      (q_full)
    );

    // Result fields.
    assign o_msg_type     = res.msg_type;
    assign o_msg_code     = res.msg_code;
    assign o_checksum_ok  = res.checksum_ok;
    assign o_status       = res.status;
    assign o_ident        = res.ident;
    assign o_sequence_res = res.sequence_res;
    assign o_aux_value    = res.aux_value;
    assign o_word_one     = res.word_one;
    assign o_word_two     = res.word_two;
    assign o_word_three   = res.word_three;
    assign o_item_count   = res.item_count;
    assign o_last         = res.last;

endmodule
